// File: rtl/multiturn_encoder_position_filter_unit_defines.svh
`ifndef MULTITURN_ENCODER_POSITION_FILTER_UNIT_DEFINES_SVH
`define MULTITURN_ENCODER_POSITION_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MTEF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MTEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mtef_pkg.sv
package mtef_pkg;

	localparam int AngleBits = 14;
	localparam int CentW     = AngleBits + 1;
	localparam int TurnW     = 16;
	localparam int FracBits  = 24;
	localparam int PosW      = 40;
	localparam int UnfW      = TurnW + FracBits + 1;
	localparam int DeltaW    = UnfW + 1;
	localparam int AccW      = DeltaW + 1;
	localparam int GainW     = 17;
	localparam int GainFrac  = 16;
	localparam int DtW       = 16;
	localparam int ProdW     = AccW + GainW;
	localparam int SW        = DeltaW + GainW - GainFrac;
	localparam int AluW      = AccW;
	localparam int IterW     = $clog2(SW > GainW ? SW : GainW);

	localparam logic [GainW-1:0]        GainReset = GainW'(410);
	localparam logic signed [CentW-1:0] HalfTurn  = CentW'(2 ** (AngleBits - 1));

	localparam int OpW = 4;
	localparam logic [OpW-1:0] OpIdle   = 4'd0;
	localparam logic [OpW-1:0] OpLoad   = 4'd1;
	localparam logic [OpW-1:0] OpUnwrap = 4'd2;
	localparam logic [OpW-1:0] OpUnf    = 4'd3;
	localparam logic [OpW-1:0] OpDelta  = 4'd4;
	localparam logic [OpW-1:0] OpMul    = 4'd5;
	localparam logic [OpW-1:0] OpPos    = 4'd6;
	localparam logic [OpW-1:0] OpAbs    = 4'd7;
	localparam logic [OpW-1:0] OpDiv    = 4'd8;
	localparam logic [OpW-1:0] OpNeg    = 4'd9;

	typedef struct packed {
		logic [AngleBits-1:0] raw_angle;
		logic [DtW-1:0]       dt_ticks;
	} sample_t;

	typedef struct packed {
		logic signed [PosW-1:0]  filtered_position;
		logic signed [PosW-1:0]  velocity;
		logic signed [TurnW-1:0] rotation_count;
	} result_t;

	typedef struct packed {
		logic [OpW-1:0] op;
		logic           res_load;
	} ctrl_t;

	typedef struct packed {
		logic dt_zero;
	} stat_t;

endpackage

// File: rtl/mtef_dp.sv
`include "multiturn_encoder_position_filter_unit_defines.svh"

module mtef_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mtef_pkg::ctrl_t                 ctrl,
	input  mtef_pkg::sample_t               sample,
	input  logic [mtef_pkg::GainW-1:0]      gain,
	output mtef_pkg::stat_t                 stat,
	output mtef_pkg::result_t               res
);

	localparam int CentW  = mtef_pkg::CentW;
	localparam int AluW   = mtef_pkg::AluW;
	localparam int AccW   = mtef_pkg::AccW;
	localparam int GainW  = mtef_pkg::GainW;
	localparam int SW     = mtef_pkg::SW;
	localparam int DtW    = mtef_pkg::DtW;
	localparam int PosW   = mtef_pkg::PosW;
	localparam int DeltaW = mtef_pkg::DeltaW;
	localparam logic signed [CentW:0] HalfX = (CentW + 1)'(mtef_pkg::HalfTurn);

	logic [mtef_pkg::AngleBits-1:0]      raw_q;
	logic [DtW-1:0]                      dt_q;
	logic signed [CentW-1:0]             last_q;
	logic signed [CentW-1:0]             negc_q;
	logic signed [mtef_pkg::TurnW-1:0]   turn_q;
	logic signed [PosW-1:0]              pos_q;
	logic signed [PosW-1:0]              vel_q;
	logic signed [DeltaW-1:0]            delta_q;
	logic signed [AccW-1:0]              hi_q;
	logic [GainW-1:0]                    lo_q;
	logic [SW-1:0]                       mag_q;
	logic [DtW-1:0]                      rem_q;
	logic                                neg_q;

	logic signed [CentW-1:0]             cent;
	logic signed [CentW-1:0]             negc;
	logic signed [CentW:0]               diff;
	logic                                wrap_up;
	logic                                wrap_dn;
	logic [mtef_pkg::ProdW-1:0]          prod_w;
	logic signed [SW-1:0]                s_w;
	logic signed [AluW-1:0]              turn_x;
	logic signed [AluW-1:0]              negc_x;
	logic signed [AluW-1:0]              pos_x;
	logic signed [AluW-1:0]              delta_x;
	logic signed [AluW-1:0]              s_x;
	logic [AluW-1:0]                     alu_a;
	logic [AluW-1:0]                     alu_b;
	logic                                alu_sub;
	logic [AluW-1:0]                     alu_sum;
	logic signed [AccW-1:0]              hi_new;
	logic                                ge;

	assign cent    = signed'({1'b0, raw_q}) - mtef_pkg::HalfTurn;
	assign negc    = mtef_pkg::HalfTurn - signed'({1'b0, raw_q});
	assign diff    = (CentW + 1)'(last_q) - (CentW + 1)'(cent);
	assign wrap_dn = diff > HalfX;
	assign wrap_up = diff < -HalfX;

	assign prod_w  = {hi_q, lo_q};
	assign s_w     = signed'(prod_w[mtef_pkg::GainFrac +: SW]);

	assign turn_x  = AluW'(turn_q);
	assign negc_x  = AluW'(negc_q);
	assign pos_x   = AluW'(pos_q);
	assign delta_x = AluW'(delta_q);
	assign s_x     = AluW'(s_w);

	// shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (ctrl.op)
			mtef_pkg::OpUnf: begin
				alu_a = turn_x <<< mtef_pkg::FracBits;
				alu_b = negc_x <<< (mtef_pkg::FracBits - mtef_pkg::AngleBits);
			end
			mtef_pkg::OpDelta: begin
				alu_a   = delta_x;
				alu_b   = pos_x;
				alu_sub = 1'b1;
			end
			mtef_pkg::OpMul: begin
				alu_a = hi_q;
				alu_b = delta_x;
			end
			mtef_pkg::OpPos: begin
				alu_a = pos_x;
				alu_b = s_x;
			end
			mtef_pkg::OpAbs: begin
				alu_b   = s_x;
				alu_sub = s_w[SW-1];
			end
			mtef_pkg::OpDiv: begin
				alu_a   = AluW'({rem_q, mag_q[SW-1]});
				alu_b   = AluW'(dt_q);
				alu_sub = 1'b1;
			end
			mtef_pkg::OpNeg: begin
				alu_b   = AluW'(mag_q);
				alu_sub = neg_q;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
		alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AluW'(alu_sub);
	end

	assign hi_new = lo_q[0] ? signed'(alu_sum[AccW-1:0]) : hi_q;
	assign ge     = ~alu_sum[AluW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			turn_q <= '0;
			pos_q  <= '0;
			vel_q  <= '0;
		end else begin
			case (ctrl.op)
				mtef_pkg::OpUnwrap: begin
					last_q <= cent;
					if (wrap_up || wrap_dn) begin
						turn_q <= turn_q + (wrap_up ? mtef_pkg::TurnW'(1) : '1);
					end
				end
				mtef_pkg::OpPos: begin
					pos_q <= alu_sum[PosW-1:0];
				end
				mtef_pkg::OpNeg: begin
					vel_q <= alu_sum[PosW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			mtef_pkg::OpLoad: begin
				raw_q <= sample.raw_angle;
				dt_q  <= sample.dt_ticks;
			end
			mtef_pkg::OpUnwrap: begin
				negc_q <= negc;
			end
			mtef_pkg::OpUnf: begin
				delta_q <= alu_sum[DeltaW-1:0];
			end
			mtef_pkg::OpDelta: begin
				delta_q <= alu_sum[DeltaW-1:0];
				hi_q    <= '0;
				lo_q    <= gain;
			end
			mtef_pkg::OpMul: begin
				hi_q <= {hi_new[AccW-1], hi_new[AccW-1:1]};
				lo_q <= {hi_new[0], lo_q[GainW-1:1]};
			end
			mtef_pkg::OpAbs: begin
				mag_q <= alu_sum[SW-1:0];
				neg_q <= s_w[SW-1];
				rem_q <= '0;
			end
			mtef_pkg::OpDiv: begin
				rem_q <= ge ? alu_sum[DtW-1:0] : {rem_q[DtW-2:0], mag_q[SW-1]};
				mag_q <= {mag_q[SW-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign stat.dt_zero          = dt_q == '0;
	assign res.filtered_position = pos_q;
	assign res.velocity          = vel_q;
	assign res.rotation_count    = turn_q;

	`MTEF_ASSERT_SAME(a_div_needs_dt, ctrl.op == mtef_pkg::OpDiv, dt_q != '0, "divide with zero dt")
	`MTEF_ASSERT_NEXT(a_rem_below_dt, ctrl.op == mtef_pkg::OpDiv, rem_q < dt_q, "remainder not below dt")

endmodule

// File: rtl/mtef_ctrl.sv
`include "multiturn_encoder_position_filter_unit_defines.svh"

module mtef_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	input  logic            res_free,
	input  mtef_pkg::stat_t stat,
	output mtef_pkg::ctrl_t ctrl,
	output logic            idle
);

	localparam int IterW = mtef_pkg::IterW;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UNWRAP = 4'd1;
	localparam logic [3:0] S_UNF    = 4'd2;
	localparam logic [3:0] S_DELTA  = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_POS    = 4'd5;
	localparam logic [3:0] S_ABS    = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_NEG    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]       state_q;
	logic [IterW-1:0] iter_q;

	always_comb begin
		ctrl.op       = mtef_pkg::OpIdle;
		ctrl.res_load = 1'b0;
		case (state_q)
			S_IDLE:   ctrl.op = sample_valid ? mtef_pkg::OpLoad : mtef_pkg::OpIdle;
			S_UNWRAP: ctrl.op = mtef_pkg::OpUnwrap;
			S_UNF:    ctrl.op = mtef_pkg::OpUnf;
			S_DELTA:  ctrl.op = mtef_pkg::OpDelta;
			S_MUL:    ctrl.op = mtef_pkg::OpMul;
			S_POS:    ctrl.op = mtef_pkg::OpPos;
			S_ABS:    ctrl.op = mtef_pkg::OpAbs;
			S_DIV:    ctrl.op = mtef_pkg::OpDiv;
			S_NEG:    ctrl.op = mtef_pkg::OpNeg;
			S_OUT:    ctrl.res_load = res_free;
			default:  ctrl.op = mtef_pkg::OpIdle;
		endcase
	end

	assign idle = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_UNWRAP;
					end
				end
				S_UNWRAP: state_q <= S_UNF;
				S_UNF:    state_q <= S_DELTA;
				S_DELTA: begin
					state_q <= S_MUL;
					iter_q  <= IterW'(mtef_pkg::GainW - 1);
				end
				S_MUL: begin
					if (iter_q == '0) begin
						state_q <= S_POS;
					end else begin
						iter_q <= iter_q - IterW'(1);
					end
				end
				S_POS: state_q <= S_ABS;
				S_ABS: begin
					state_q <= stat.dt_zero ? S_OUT : S_DIV;
					iter_q  <= IterW'(mtef_pkg::SW - 1);
				end
				S_DIV: begin
					if (iter_q == '0) begin
						state_q <= S_NEG;
					end else begin
						iter_q <= iter_q - IterW'(1);
					end
				end
				S_NEG: state_q <= S_OUT;
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MTEF_ASSERT_NEXT(a_accept_starts, (state_q == S_IDLE) && sample_valid, state_q == S_UNWRAP, "accepted transaction did not start")
	`MTEF_ASSERT_NEXT(a_mul_holds, (state_q == S_MUL) && (iter_q != '0), state_q == S_MUL, "multiply left early")
	`MTEF_ASSERT_NEXT(a_dt_zero_skip, (state_q == S_ABS) && stat.dt_zero, state_q == S_OUT, "zero dt did not skip divide")

endmodule

// File: rtl/multiturn_encoder_position_filter_unit.sv
// multi-turn encoder unwrap with first-order low-pass position filter
// sample channel: sample_valid / sample_stall carry raw_angle and dt_ticks;
//   sample_stall is high while a transaction is being worked on
// result channel: result_valid / result_stall carry filtered_position,
//   velocity and rotation_count, one result per sample
// gain channel: gain_valid / gain_ready writes filter_gain (Q1.16), taken
//   only while the block is idle; reset value 410
// steps: unwrap, unfold, delta, multiply, position, abs, divide, negate and
//   output, with divide and negate skipped on zero dt; one multiply
//   iteration per gain bit (17) and one divide iteration per quotient bit
//   (43) through one shared 43-bit adder
// the next sample waits until the block is idle again
// reset clears turn count, last sample, position and velocity to zero
// a stalled result holds in the output register; the next sample is still
//   accepted and worked on, and the block waits at the end for the
//   output register to free up
module multiturn_encoder_position_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  mtef_pkg::sample_t            sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output mtef_pkg::result_t            result,
	input  logic                         gain_valid,
	output logic                         gain_ready,
	input  logic [mtef_pkg::GainW-1:0]   gain_data
);

	logic [mtef_pkg::GainW-1:0] gain_q;
	logic                       res_valid_q;
	mtef_pkg::result_t          res_q;
	mtef_pkg::result_t          dp_res;
	mtef_pkg::ctrl_t            ctrl;
	mtef_pkg::stat_t            stat;
	logic                       idle;
	logic                       res_free;

	assign res_free     = ~res_valid_q | ~result_stall;
	assign sample_stall = ~idle;
	assign gain_ready   = idle;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	mtef_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.res_free     (res_free),
		.stat         (stat),
		.ctrl         (ctrl),
		.idle         (idle)
	);

	mtef_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample),
		.gain   (gain_q),
		.stat   (stat),
		.res    (dp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= mtef_pkg::GainReset;
			res_valid_q <= 1'b0;
		end else begin
			if (gain_valid && gain_ready) begin
				gain_q <= gain_data;
			end
			if (ctrl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			res_q <= dp_res;
		end
	end

endmodule

// File: tb/sv/multiturn_encoder_position_filter_unit_tb.sv
module multiturn_encoder_position_filter_unit_tb;

	localparam int QuietLimit = 3000;
	localparam int LongHold   = 400;
	localparam int AngleBits  = mtef_pkg::AngleBits;
	localparam int GainW      = mtef_pkg::GainW;
	localparam int TurnW      = mtef_pkg::TurnW;
	localparam int PosW       = mtef_pkg::PosW;
	localparam int DtW        = mtef_pkg::DtW;
	localparam int FracBits   = mtef_pkg::FracBits;
	localparam int GainFrac   = mtef_pkg::GainFrac;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	mtef_pkg::sample_t sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	mtef_pkg::result_t result;
	logic              gain_valid = 1'b0;
	logic              gain_ready;
	logic [GainW-1:0]  gain_data = '0;

	// predictor state
	logic [GainW-1:0] gain_q16 = mtef_pkg::GainReset;
	int               prev_cent = 0;
	logic [TurnW-1:0] turn_total = '0;
	logic [PosW-1:0]  pos_acc = '0;
	logic [PosW-1:0]  vel_acc = '0;

	mtef_pkg::result_t predicted_results[$];
	mtef_pkg::result_t want;

	int  mismatches = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	int  gain_writes = 0;
	int  zero_dt_samples = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	int  burst_left = 0;
	bit  hold_request = 0;
	bit  idling_on = 1;

	multiturn_encoder_position_filter_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.gain_valid   (gain_valid),
		.gain_ready   (gain_ready),
		.gain_data    (gain_data)
	);

	always #5 clk = ~clk;

	task automatic advance_filter(input mtef_pkg::sample_t smp, output mtef_pkg::result_t r);
		int     cent;
		int     diff;
		longint tc;
		longint unf;
		longint delta;
		longint step;
		longint quot;
		cent = int'(smp.raw_angle) - (1 << (AngleBits - 1));
		diff = prev_cent - cent;
		if (diff > (1 << (AngleBits - 1)) || diff < -(1 << (AngleBits - 1))) begin
			turn_total = turn_total + ((diff < 0) ? 16'h0001 : 16'hFFFF);
		end
		prev_cent = cent;
		tc = longint'($signed(turn_total));
		unf = (tc <<< FracBits) - (longint'(cent) <<< (FracBits - AngleBits));
		delta = unf - longint'($signed(pos_acc));
		step = (delta * longint'(gain_q16)) >>> GainFrac;
		pos_acc = pos_acc + step[PosW-1:0];
		if (smp.dt_ticks != '0) begin
			quot = step / longint'(smp.dt_ticks);
			vel_acc = quot[PosW-1:0];
		end
		r.filtered_position = pos_acc;
		r.velocity = vel_acc;
		r.rotation_count = turn_total;
	endtask

	task automatic send_sample(input int angle, input int ticks);
		mtef_pkg::sample_t smp;
		mtef_pkg::result_t r;
		smp.raw_angle = angle[AngleBits-1:0];
		smp.dt_ticks = ticks[DtW-1:0];
		if (idling_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= smp;
		do @(posedge clk); while (sample_stall);
		advance_filter(smp, r);
		predicted_results.push_back(r);
		samples_sent++;
		if (smp.dt_ticks == '0) zero_dt_samples++;
	endtask

	task automatic wait_results_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gain(input int value);
		wait_results_drained();
		gain_valid <= 1'b1;
		gain_data <= value[GainW-1:0];
		do @(posedge clk); while (!gain_ready);
		gain_valid <= 1'b0;
		gain_q16 = value[GainW-1:0];
		gain_writes++;
	endtask

	function automatic int random_ticks();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(0, 65535);
			3: return 1;
			default: return $urandom_range(1, 2000);
		endcase
	endfunction

	// rotation runs at random speed with jitter, with random-angle dropouts mixed in
	task automatic run_rotation(input int count);
		int angle;
		int speed;
		int run_left;
		int i;
		angle = $urandom_range(0, 16383);
		run_left = 0;
		speed = 0;
		for (i = 0; i < count; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(5, 60);
				case ($urandom_range(0, 3))
					0: speed = $urandom_range(0, 128) - 64;
					1: speed = $urandom_range(0, 2048) - 1024;
					2: speed = $urandom_range(0, 16382) - 8191;
					default: speed = $urandom_range(0, 1) ? 8192 : -8192;
				endcase
			end
			run_left--;
			if ($urandom_range(0, 19) == 0) begin
				send_sample($urandom_range(0, 16383), random_ticks());
			end else begin
				angle = (angle + speed + $urandom_range(0, 6) - 3 + 32768) % 16384;
				send_sample(angle, random_ticks());
			end
		end
	endtask

	task automatic test_field_extremes();
		send_sample(0, 0);
		send_sample(16383, 65535);
		send_sample(8192, 1);
		send_sample(8191, 0);
		send_sample(0, 65535);
	endtask

	task automatic test_turn_boundaries();
		int t;
		write_gain(65536);
		send_sample(0, 1);
		send_sample(8192, 1);
		send_sample(0, 1);
		send_sample(8193, 1);
		send_sample(0, 1);
		for (t = 0; t < 2; t++) begin
			send_sample(5500, 100);
			send_sample(11000, 100);
			send_sample(0, 100);
		end
		for (t = 0; t < 2; t++) begin
			send_sample(11000, 7);
			send_sample(5500, 7);
			send_sample(0, 7);
		end
	endtask

	task automatic test_gain_extremes();
		write_gain(0);
		send_sample(12000, 3);
		send_sample(300, 0);
		write_gain(131071);
		send_sample(16383, 1);
		send_sample(0, 65535);
	endtask

	task automatic test_random_gains();
		write_gain($urandom_range(0, 131071));
		run_rotation(280);
		write_gain(65536);
		run_rotation(280);
		write_gain(131071);
		run_rotation(280);
		write_gain(410);
		run_rotation(280);
		write_gain($urandom_range(1, 2000));
		run_rotation(280);
	endtask

	task automatic test_output_hold();
		int i;
		hold_request = 1;
		for (i = 0; i < 8; i++) send_sample($urandom_range(0, 16383), random_ticks());
		wait_results_drained();
	endtask

	task automatic test_drain_pause();
		run_rotation(20);
		wait_results_drained();
		run_rotation(20);
	endtask

	task automatic test_steady_stream();
		write_gain($urandom_range(0, 131071));
		idling_on = 0;
		run_rotation(150);
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			results_seen++;
			if (predicted_results.size() == 0) begin
				$error("result transaction with no sample pending");
				mismatches++;
			end else begin
				want = predicted_results.pop_front();
				if (result.filtered_position !== want.filtered_position) begin
					$error("filtered_position: expected %0d, actual %0d",
						want.filtered_position, result.filtered_position);
					mismatches++;
				end
				if (result.velocity !== want.velocity) begin
					$error("velocity: expected %0d, actual %0d", want.velocity, result.velocity);
					mismatches++;
				end
				if (result.rotation_count !== want.rotation_count) begin
					$error("rotation_count: expected %0d, actual %0d",
						want.rotation_count, result.rotation_count);
					mismatches++;
				end
			end
		end
		if (hold_request) begin
			hold_left = LongHold;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			result_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			burst_left = $urandom_range(1, 9) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid === 1'b1 && !result_stall) ||
			(gain_valid && gain_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_turn_boundaries();
		test_gain_extremes();
		test_random_gains();
		test_output_hold();
		test_drain_pause();
		test_steady_stream();
		wait_results_drained();
		repeat (80) @(posedge clk);
		$display("ran %0d samples (%0d with zero dt) and checked %0d results", samples_sent,
			zero_dt_samples, results_seen);
		$display("filter gain rewritten %0d times, from 0 up to full scale and overshoot",
			gain_writes);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
